### rtl/core/dds_pkg.sv
// ----------------------------------------------------------------------------
// dds_pkg: shared types and constants for the date day span block
// Field widths, result status codes and the calendar tables that turn a
// month number into the count of days before it.
// ----------------------------------------------------------------------------
package dds_pkg;

	// Field widths.
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int SPAN_W  = 23;
	localparam int STAT_W  = 2;

	// A day number for years up to 9999 stays below 2**22.
	localparam int DNUM_W  = 22;
	localparam int CUM_W   = 9;
	localparam int CENT_W  = 7;

	// Year divided by 100 as (year * CENT_RECIP) >> CENT_SHIFT, exact below 10923.
	localparam int CENT_RECIP_W = 13;
	localparam int CENT_SHIFT   = 19;
	localparam int PROD_W       = YEAR_W + CENT_RECIP_W;
	localparam logic [CENT_RECIP_W-1:0] CENT_RECIP = 13'd5243;

	localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
	localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd12;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_NULL      = 2'd1,
		ST_BAD_MONTH = 2'd2
	} status_t;

	// Days in the months before the given month of a common year.
	function automatic logic [CUM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
		logic [CUM_W-1:0] c;
		case (m)
			4'd2:    c = 9'd31;
			4'd3:    c = 9'd59;
			4'd4:    c = 9'd90;
			4'd5:    c = 9'd120;
			4'd6:    c = 9'd151;
			4'd7:    c = 9'd181;
			4'd8:    c = 9'd212;
			4'd9:    c = 9'd243;
			4'd10:   c = 9'd273;
			4'd11:   c = 9'd304;
			4'd12:   c = 9'd334;
			default: c = 9'd0;
		endcase
		return c;
	endfunction

endpackage

### rtl/core/dds_day_num.sv
// ----------------------------------------------------------------------------
// dds_day_num: three-stage day number converter
// Turns one date into its day count from 0000-01-00 under the proleptic
// Gregorian leap rule. All stages advance together on the enable.
// ----------------------------------------------------------------------------
module dds_day_num
	import dds_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic [YEAR_W-1:0]  year,
	input  logic [MONTH_W-1:0] month,
	input  logic [DAY_W-1:0]   day,
	output logic [DNUM_W-1:0]  day_num
);

	// Stage 1: capture the date and the century count by reciprocal multiply.
	logic [PROD_W-1:0]  cent_prod;
	logic [YEAR_W-1:0]  year_s1;
	logic [MONTH_W-1:0] month_s1;
	logic [DAY_W-1:0]   day_s1;
	logic [CENT_W-1:0]  cent_s1;

	assign cent_prod = PROD_W'(year) * PROD_W'(CENT_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			year_s1  <= year;
			month_s1 <= month;
			day_s1   <= day;
			cent_s1  <= cent_prod[CENT_SHIFT +: CENT_W];
		end
	end

	// Stage 2: leap test, century terms of the previous year, year times 365.
	logic [YEAR_W-1:0]  cent_rem;
	logic               cent_year;
	logic               leap;
	logic [YEAR_W-1:0]  year_prev;
	logic [CENT_W-1:0]  prev_cent;
	logic [DNUM_W-1:0]  yr_days_s2;
	logic [YEAR_W-3:0]  quad_s2;
	logic [CENT_W-1:0]  cent_s2;
	logic [CUM_W:0]     cum_s2;
	logic [DAY_W-1:0]   day_s2;
	logic               year_zero_s2;

	always_comb begin
		cent_rem  = year_s1 - YEAR_W'(cent_s1) * YEAR_W'(100);
		cent_year = (cent_rem == '0);
		leap      = (year_s1[1:0] == 2'b00) && (!cent_year || cent_s1[1:0] == 2'b00);
		year_prev = year_s1 - YEAR_W'(1);
		// The previous year crosses a century only when this year starts one.
		prev_cent = cent_year ? cent_s1 - CENT_W'(1) : cent_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yr_days_s2   <= DNUM_W'(year_s1) * DNUM_W'(365);
			quad_s2      <= year_prev[YEAR_W-1:2];
			cent_s2      <= prev_cent;
			cum_s2       <= {1'b0, days_before_month(month_s1)}
				+ (CUM_W+1)'(leap && month_s1 > 4'd2);
			day_s2       <= day_s1;
			year_zero_s2 <= (year_s1 == '0);
		end
	end

	// Stage 3: add up the day number.
	logic [DNUM_W-1:0] in_year;
	logic [DNUM_W-1:0] whole_years;
	logic [DNUM_W-1:0] day_num_s3;

	always_comb begin
		in_year     = DNUM_W'(cum_s2) + DNUM_W'(day_s2);
		whole_years = yr_days_s2 + DNUM_W'(quad_s2) - DNUM_W'(cent_s2)
			+ DNUM_W'(cent_s2[CENT_W-1:2]) + DNUM_W'(1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			day_num_s3 <= year_zero_s2 ? in_year : whole_years + in_year;
		end
	end

	assign day_num = day_num_s3;

endmodule

### rtl/core/date_day_span_top.sv
// ----------------------------------------------------------------------------
// date_day_span_top: signed day span between two calendar dates
// Checks both dates, converts each to a day number and returns the
// difference with a status code.
// ----------------------------------------------------------------------------
// Usage:
// A request carries two dates (year, month, day, null mark) and a flag
// saying both are plain dates. It is taken at a clock edge with in_valid
// high and in_stall low. The result appears on day_span and status with
// out_valid; the receiver takes it at an edge where out_stall is low.
// The block takes one request per cycle while no result is held back by
// out_stall: a four-stage pipeline where both day number converters and
// the status logic advance together.
// Status 0 gives the span (first date minus second, may be negative),
// 1 a null result (null mark, non-date flag or year above 9999), 2 an
// invalid month. day_span is zero unless status is 0.
// While out_stall holds back a valid result, the whole pipeline freezes
// and in_stall rises; nothing is lost or repeated. Empty stages still
// fill while the output waits only if the output holds no result.
// Reset clears all stage valid bits; the first request is taken at the
// first edge after arst_n is released.
// ----------------------------------------------------------------------------
module date_day_span_top
	import dds_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [YEAR_W-1:0]  first_year,
	input  logic [MONTH_W-1:0] first_month,
	input  logic [DAY_W-1:0]   first_day,
	input  logic               first_null,
	input  logic [YEAR_W-1:0]  second_year,
	input  logic [MONTH_W-1:0] second_month,
	input  logic [DAY_W-1:0]   second_day,
	input  logic               second_null,
	input  logic               both_dates,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [SPAN_W-1:0]  day_span,
	output logic [STAT_W-1:0]  status
);

	// The pipeline moves unless a finished result is held at the output.
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Status decision on the raw request.
	status_t status_in;
	logic    bad_month;

	always_comb begin
		bad_month = (first_month == '0) || (first_month > MONTH_LAST)
			|| (second_month == '0) || (second_month > MONTH_LAST);
		if (first_null || second_null || !both_dates
			|| first_year > YEAR_MAX || second_year > YEAR_MAX) begin
			status_in = ST_NULL;
		end else if (bad_month) begin
			status_in = ST_BAD_MONTH;
		end else begin
			status_in = ST_OK;
		end
	end

	// Valid bits and status travel beside the converters.
	logic    valid_s1, valid_s2, valid_s3, valid_s4;
	status_t status_s1, status_s2, status_s3, status_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_s1 <= status_in;
			status_s2 <= status_s1;
			status_s3 <= status_s2;
			status_s4 <= status_s3;
		end
	end

	// One converter per date.
	logic [DNUM_W-1:0] first_num;
	logic [DNUM_W-1:0] second_num;

	dds_day_num u_first (
		.clk     (clk),
		.en      (en),
		.year    (first_year),
		.month   (first_month),
		.day     (first_day),
		.day_num (first_num)
	);

	dds_day_num u_second (
		.clk     (clk),
		.en      (en),
		.year    (second_year),
		.month   (second_month),
		.day     (second_day),
		.day_num (second_num)
	);

	// Output stage: the difference of day numbers, zero for any other status.
	logic [SPAN_W-1:0] span_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			span_s4 <= (status_s3 == ST_OK)
				? SPAN_W'(first_num) - SPAN_W'(second_num) : '0;
		end
	end

	assign out_valid = valid_s4;
	assign day_span  = span_s4;
	assign status    = status_s4;

	// A non-valid status never carries a span.
	a_span_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> day_span == '0)
		else $error("day_span nonzero with non-valid status");

	// The input is held back only while the output holds a result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("in_stall raised without a held result");

	// A frozen pipeline keeps its inner items.
	a_freeze_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> valid_s2 == $past(valid_s2) && valid_s3 == $past(valid_s3)
			&& status_s3 == $past(status_s3))
		else $error("pipeline stage changed while frozen");

endmodule
